@@ src/hcb_pkg.sv @@
// Shared constants for the Huffman code builder.
package hcb_pkg;
	localparam int SYM_W  = 5;
	localparam int LEN_W  = 5;
	localparam int BITS_W = 31;
endpackage

@@ src/hcb_if.sv @@
// Valid/ready channel interface used for input and result items.
interface hcb_if #(parameter int W = 1) ();
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ src/huffman_code_builder.sv @@
// Huffman code builder: loads weights, merges nodes, emits codes.
// Loading accepts one item per cycle while no result is pending. Each of the n-1 merges for new
// node k makes three passes over nodes 1 to k-1, one registered table read a cycle, then writes
// in states MRG1, MRG2 and MRG3. Each code walk then climbs L levels for a code of L bits.
// The input is not ready while a set is merged and its codes are emitted.
// arst_n clears the sequencer and the symbol count; the node tables are not cleared.
module huffman_code_builder #(
	parameter int MAX_SYMBOLS = 32,
	parameter int WEIGHT_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	hcb_if.sink   in_ch,
	hcb_if.source out_ch
);
	localparam int NODES = 2 * MAX_SYMBOLS;
	localparam int IW    = $clog2(NODES);
	localparam int CW    = $clog2(MAX_SYMBOLS + 1);
	localparam int NW    = WEIGHT_BITS + IW;
	localparam int LW    = $clog2(NODES);

	localparam logic [3:0] ST_LOAD  = 4'd0;
	localparam logic [3:0] ST_FIRST = 4'd1;
	localparam logic [3:0] ST_SCAN1 = 4'd2;
	localparam logic [3:0] ST_SCAN2 = 4'd3;
	localparam logic [3:0] ST_MRG1  = 4'd4;
	localparam logic [3:0] ST_MRG2  = 4'd5;
	localparam logic [3:0] ST_MRG3  = 4'd6;
	localparam logic [3:0] ST_WREQ  = 4'd7;
	localparam logic [3:0] ST_WPAR  = 4'd8;
	localparam logic [3:0] ST_WRGT  = 4'd9;
	localparam logic [3:0] ST_OUT   = 4'd10;

	logic [NW-1:0] wt_mem [NODES];
	logic [IW-1:0] par_mem [NODES];
	logic [IW-1:0] rgt_mem [NODES];

	logic [NW-1:0] wt_rd_q;
	logic [IW-1:0] par_rd_q, rgt_rd_q;

	logic [3:0]    state_q;
	logic [CW-1:0] count_q, n_q;
	logic [IW-1:0] k_q, i_q, ri_q, s1_q, s2_q, node_q, p_q;
	logic          got1_q, iss_q, rv_q;
	logic [NW-1:0] w1_q, w2_q;
	logic [LW-1:0] len_q;
	logic [63:0]   bits_q;
	logic [CW-1:0] sym_q;
	logic          out_valid_q;
	logic [hcb_pkg::SYM_W-1:0]  o_sym_q;
	logic [hcb_pkg::LEN_W-1:0]  o_len_q;
	logic [hcb_pkg::BITS_W-1:0] o_bits_q;
	logic o_cv_q, o_last_q;

	logic [15:0] in_w;
	logic        in_last;
	assign in_w    = in_ch.data[16:1];
	assign in_last = in_ch.data[0];

	logic [CW-1:0] n_new;
	logic [IW-1:0] top;
	logic          accept;
	logic          free_r;
	logic          next_pass;
	logic [NW-1:0] w_in;
	logic [IW-1:0] rd_addr;
	logic          wt_we, par_we, rgt_we;
	logic [IW-1:0] wt_wa, par_wa, par_wd, rgt_wd;
	logic [NW-1:0] wt_wd;

	assign n_new  = (count_q >= CW'(MAX_SYMBOLS)) ? CW'(1) : count_q + CW'(1);
	assign top    = IW'(k_q - IW'(1));
	assign accept = in_ch.valid && in_ch.ready;
	assign free_r = (par_rd_q == '0);
	assign rgt_wd = (w1_q > w2_q) ? s1_q : s2_q;
	always_comb begin
		w_in = '0;
		if (WEIGHT_BITS >= 16) w_in[15:0] = in_w;
		else w_in[WEIGHT_BITS-1:0] = in_w[WEIGHT_BITS-1:0];
	end

	// The first-free search also stops once the second parentless node shows up.
	always_comb begin
		unique case (state_q)
			ST_FIRST: next_pass = rv_q && ((free_r && got1_q) || ri_q == top);
			ST_SCAN1, ST_SCAN2: next_pass = rv_q && ri_q == top;
			default: next_pass = 1'b0;
		endcase
	end

	always_comb begin
		unique case (state_q)
			ST_FIRST, ST_SCAN1, ST_SCAN2: rd_addr = i_q;
			ST_WRGT: rd_addr = p_q;
			default: rd_addr = node_q;
		endcase
	end

	always_comb begin
		wt_we  = 1'b0;
		wt_wa  = IW'(n_new);
		wt_wd  = w_in;
		par_we = 1'b0;
		par_wa = IW'(n_new);
		par_wd = '0;
		rgt_we = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				wt_we  = accept;
				par_we = accept;
			end
			ST_MRG1: begin
				wt_we  = 1'b1;
				wt_wa  = k_q;
				wt_wd  = w1_q + w2_q;
				par_we = 1'b1;
				par_wa = s1_q;
				par_wd = k_q;
				rgt_we = 1'b1;
			end
			ST_MRG2: begin
				par_we = 1'b1;
				par_wa = s2_q;
				par_wd = k_q;
			end
			ST_MRG3: begin
				par_we = 1'b1;
				par_wa = k_q;
			end
			default: begin
			end
		endcase
	end

	assign in_ch.ready = (state_q == ST_LOAD) && !out_valid_q;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = {o_sym_q, o_len_q, o_bits_q, o_cv_q, o_last_q};

	// Node tables: one write and one registered read per table each cycle.
	always_ff @(posedge clk) begin
		if (wt_we) wt_mem[wt_wa] <= wt_wd;
		if (par_we) par_mem[par_wa] <= par_wd;
		if (rgt_we) rgt_mem[k_q] <= rgt_wd;
		wt_rd_q  <= wt_mem[rd_addr];
		par_rd_q <= par_mem[rd_addr];
		rgt_rd_q <= rgt_mem[par_rd_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			n_q <= '0; k_q <= '0; i_q <= '0; ri_q <= '0; s1_q <= '0; s2_q <= '0;
			node_q <= '0; p_q <= '0; got1_q <= 1'b0; iss_q <= 1'b0; rv_q <= 1'b0;
			w1_q <= '0; w2_q <= '0; len_q <= '0; bits_q <= '0; sym_q <= '0;
			o_sym_q <= '0; o_len_q <= '0; o_bits_q <= '0; o_cv_q <= 1'b0; o_last_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
			// Scan passes read one node a cycle; its data comes back in the next cycle.
			if (state_q == ST_FIRST || state_q == ST_SCAN1 || state_q == ST_SCAN2) begin
				if (next_pass) begin
					i_q   <= IW'(1);
					iss_q <= 1'b1;
					rv_q  <= 1'b0;
				end else begin
					ri_q <= i_q;
					rv_q <= iss_q;
					if (iss_q) begin
						if (i_q == top) iss_q <= 1'b0;
						else i_q <= i_q + IW'(1);
					end
				end
			end
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (in_last || n_new == CW'(MAX_SYMBOLS)) begin
							count_q <= '0;
							n_q     <= n_new;
							if (n_new < CW'(2)) begin
								out_valid_q <= 1'b1;
								o_sym_q <= '0; o_len_q <= '0; o_bits_q <= '0;
								o_cv_q <= 1'b0; o_last_q <= 1'b1;
							end else begin
								k_q    <= IW'(n_new) + IW'(1);
								i_q    <= IW'(1);
								iss_q  <= 1'b1;
								rv_q   <= 1'b0;
								got1_q <= 1'b0;
								state_q <= ST_FIRST;
							end
						end else begin
							count_q <= n_new;
						end
					end
				end
				// Find the first two parentless nodes in index order.
				ST_FIRST: begin
					if (rv_q && free_r) begin
						if (!got1_q) begin
							s1_q <= ri_q; w1_q <= wt_rd_q; got1_q <= 1'b1;
						end else begin
							s2_q <= ri_q; w2_q <= wt_rd_q;
						end
					end
					if (next_pass) state_q <= ST_SCAN1;
				end
				ST_SCAN1: begin
					if (rv_q && free_r && ri_q != s2_q && w1_q > wt_rd_q) begin
						s1_q <= ri_q; w1_q <= wt_rd_q;
					end
					if (next_pass) state_q <= ST_SCAN2;
				end
				ST_SCAN2: begin
					if (rv_q && free_r && ri_q != s1_q && w2_q > wt_rd_q) begin
						s2_q <= ri_q; w2_q <= wt_rd_q;
					end
					if (next_pass) state_q <= ST_MRG1;
				end
				// The lighter child goes left; only the right link is kept for the walk.
				ST_MRG1: state_q <= ST_MRG2;
				ST_MRG2: state_q <= ST_MRG3;
				ST_MRG3: begin
					if (k_q == IW'(2 * n_q - 1)) begin
						sym_q <= '0; node_q <= IW'(1); len_q <= '0; bits_q <= '0;
						state_q <= ST_WREQ;
					end else begin
						k_q <= k_q + IW'(1); got1_q <= 1'b0;
						state_q <= ST_FIRST;
					end
				end
				ST_WREQ: state_q <= ST_WPAR;
				// Climb from the leaf to the root, through WPAR and then WRGT for each level.
				ST_WPAR: begin
					if (par_rd_q != '0) begin
						p_q     <= par_rd_q;
						state_q <= ST_WRGT;
					end else if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						o_sym_q  <= hcb_pkg::SYM_W'(sym_q);
						o_len_q  <= hcb_pkg::LEN_W'(len_q);
						o_bits_q <= bits_q[hcb_pkg::BITS_W-1:0];
						o_cv_q   <= 1'b1;
						o_last_q <= (sym_q + CW'(1) == n_q);
						state_q  <= ST_OUT;
					end
				end
				ST_WRGT: begin
					if (rgt_rd_q == node_q) bits_q[len_q] <= 1'b1;
					len_q   <= len_q + LW'(1);
					node_q  <= p_q;
					state_q <= ST_WPAR;
				end
				ST_OUT: begin
					if (sym_q + CW'(1) == n_q) state_q <= ST_LOAD;
					else begin
						sym_q  <= sym_q + CW'(1);
						node_q <= IW'(sym_q) + IW'(2);
						len_q  <= '0; bits_q <= '0;
						state_q <= ST_WREQ;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> state_q == ST_LOAD) else $error("ready outside load");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |=> out_valid_q) else $error("result dropped");
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |=> $stable(out_ch.data)) else $error("result changed");
	a_merge_pair: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MRG1 |-> s1_q != s2_q) else $error("same child twice");
endmodule

@@ test/hcb_tb_if.sv @@
// The testbench uses the channel interface declared with the source files; nothing is declared here.
`timescale 1ns / 100ps

@@ test/tb_huffman_code_builder.sv @@
// Testbench for the Huffman code builder: directed and random weight sets checked against a predictor.
`timescale 1ns / 100ps
module tb_huffman_code_builder;
	localparam int MAX_SYM = 32;
	localparam int IN_W = 17;
	localparam int OUT_W = hcb_pkg::SYM_W + hcb_pkg::LEN_W + hcb_pkg::BITS_W + 2;

	typedef struct packed {
		logic [hcb_pkg::SYM_W-1:0]  symbol;
		logic [hcb_pkg::LEN_W-1:0]  code_length;
		logic [hcb_pkg::BITS_W-1:0] code_bits;
		logic                       code_valid;
		logic                       last_code;
	} code_t;

	typedef struct {
		logic [15:0] weight;
		logic        last_weight;
		logic        lone_symbol;
	} row_t;

	logic clk;
	logic arst_n;
	hcb_if #(.W(IN_W))  in_ch ();
	hcb_if #(.W(OUT_W)) out_ch ();

	huffman_code_builder u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	code_t code_queue[$];
	int errors = 0;
	bit calm = 0;

	// Predictor state: node table indexed from 1, link 0 means none.
	longint unsigned tree_weight[2*MAX_SYM];
	int tree_parent[2*MAX_SYM];
	int tree_left[2*MAX_SYM];
	int tree_right[2*MAX_SYM];
	int held_count = 0;

	function automatic void pick_pair(int top, output int a, output int b);
		int s1, s2, t;
		s1 = 1;
		s2 = 1;
		for (int i = 1; i <= top; i++)
			if (tree_parent[i] == 0) begin
				s1 = i;
				break;
			end
		for (int i = s1 + 1; i <= top; i++)
			if (tree_parent[i] == 0) begin
				s2 = i;
				break;
			end
		for (int i = 1; i <= top; i++)
			if (tree_weight[s1] > tree_weight[i] && tree_parent[i] == 0 && i != s2)
				s1 = i;
		for (int i = 1; i <= top; i++)
			if (tree_weight[s2] > tree_weight[i] && tree_parent[i] == 0 && i != s1)
				s2 = i;
		if (tree_weight[s1] > tree_weight[s2]) begin
			t = s1;
			s1 = s2;
			s2 = t;
		end
		a = s1;
		b = s2;
	endfunction

	function automatic void predict_codes(logic [15:0] w, logic last);
		int n, s1, s2, node, len;
		longint unsigned bits;
		code_t c;
		if (held_count >= MAX_SYM)
			held_count = 0;
		n = held_count + 1;
		tree_weight[n] = 64'(w);
		tree_parent[n] = 0;
		tree_left[n] = 0;
		tree_right[n] = 0;
		held_count = n;
		if (!last && n < MAX_SYM)
			return;
		held_count = 0;
		if (n < 2) begin
			c = '0;
			c.last_code = 1'b1;
			code_queue.push_back(c);
			return;
		end
		for (int k = n + 1; k <= 2 * n - 1; k++) begin
			tree_weight[k] = 0;
			tree_parent[k] = 0;
			tree_left[k] = 0;
			tree_right[k] = 0;
		end
		for (int k = n + 1; k <= 2 * n - 1; k++) begin
			pick_pair(k - 1, s1, s2);
			tree_parent[s1] = k;
			tree_parent[s2] = k;
			tree_left[k] = s1;
			tree_right[k] = s2;
			tree_weight[k] = tree_weight[s1] + tree_weight[s2];
		end
		for (int k = 1; k <= n; k++) begin
			node = k;
			len = 0;
			bits = 0;
			while (tree_parent[node] != 0 && len < 63) begin
				if (tree_right[tree_parent[node]] == node)
					bits |= 64'd1 << len;
				len++;
				node = tree_parent[node];
			end
			c.symbol = hcb_pkg::SYM_W'(k - 1);
			c.code_length = hcb_pkg::LEN_W'(len);
			c.code_bits = bits[hcb_pkg::BITS_W-1:0];
			c.code_valid = 1'b1;
			c.last_code = (k == n);
			code_queue.push_back(c);
		end
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("Verification failed");
		$finish;
	end

	// Result side: check every accepted item, then pick the next ready value.
	int sink_hold = 0;
	always @(posedge clk) begin
		code_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (code_queue.size() == 0) begin
				$error("unexpected result item %p", got);
				errors++;
			end else begin
				want = code_queue.pop_front();
				if (got.symbol !== want.symbol) begin
					$error("symbol: expected %0d, got %0d", want.symbol, got.symbol);
					errors++;
				end
				if (got.code_length !== want.code_length) begin
					$error("code_length: expected %0d, got %0d", want.code_length,
						got.code_length);
					errors++;
				end
				if (got.code_bits !== want.code_bits) begin
					$error("code_bits: expected %h, got %h", want.code_bits, got.code_bits);
					errors++;
				end
				if (got.code_valid !== want.code_valid) begin
					$error("code_valid: expected %b, got %b", want.code_valid, got.code_valid);
					errors++;
				end
				if (got.last_code !== want.last_code) begin
					$error("last_code: expected %b, got %b", want.last_code, got.last_code);
					errors++;
				end
			end
		end
		if (sink_hold > 0) begin
			sink_hold--;
			out_ch.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			sink_hold = $urandom_range(1, 10) - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	task automatic send_weight(logic [15:0] w, logic last);
		in_ch.valid <= 1'b1;
		in_ch.data <= {w, last};
		do @(posedge clk); while (!in_ch.ready);
		predict_codes(w, last);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	task automatic drain(int limit);
		int waited;
		waited = 0;
		in_ch.valid <= 1'b0;
		while (code_queue.size() != 0 && waited < limit) begin
			@(posedge clk);
			waited++;
		end
	endtask

	row_t rows[23] = '{
		'{16'd1, 1'b1, 1'b1},
		'{16'hFFFF, 1'b1, 1'b1},
		'{16'd1, 1'b0, 1'b0}, '{16'hFFFF, 1'b1, 1'b0},
		'{16'hFFFF, 1'b0, 1'b0}, '{16'hFFFF, 1'b1, 1'b0},
		'{16'd5, 1'b0, 1'b0}, '{16'd5, 1'b0, 1'b0}, '{16'd5, 1'b1, 1'b0},
		'{16'd9, 1'b0, 1'b0}, '{16'd1, 1'b0, 1'b0}, '{16'd4, 1'b0, 1'b0},
		'{16'd1, 1'b0, 1'b0}, '{16'd9, 1'b1, 1'b0},
		'{16'd1, 1'b0, 1'b0}, '{16'd1, 1'b0, 1'b0}, '{16'd2, 1'b0, 1'b0},
		'{16'd4, 1'b0, 1'b0}, '{16'd8, 1'b0, 1'b0}, '{16'd16, 1'b0, 1'b0},
		'{16'd32, 1'b0, 1'b0}, '{16'hAAAA, 1'b0, 1'b0}, '{16'h5555, 1'b1, 1'b0}
	};

	initial begin
		int set_size, wmax, sent;
		bit drained;
		code_t lone;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		drained = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		lone = '0;
		lone.last_code = 1'b1;
		foreach (rows[i]) begin
			send_weight(rows[i].weight, rows[i].last_weight);
			// A lone symbol gives a fixed result that needs no tree.
			if (rows[i].lone_symbol && code_queue.size() > 0)
				code_queue[$] = lone;
		end

		sent = 0;
		while (sent < 500) begin
			case ($urandom_range(0, 9))
				0: set_size = 1;
				1: set_size = MAX_SYM;
				default: set_size = $urandom_range(2, 8);
			endcase
			// Narrow weight ranges make ties common.
			wmax = ($urandom_range(0, 1) == 0) ? 4 : 16'hFFFF;
			for (int k = 0; k < set_size; k++) begin
				// A full table closes the set without a last marker.
				send_weight(16'($urandom_range(1, wmax)),
					(k == set_size - 1 && set_size < MAX_SYM) ? 1'b1 : 1'b0);
				sent++;
			end
			if (!drained && sent > 250) begin
				drain(100000);
				drained = 1;
			end
			if (sent > 420)
				calm = 1;
		end
		in_ch.valid <= 1'b0;

		drain(200000);
		repeat (100) @(posedge clk);
		if (code_queue.size() != 0) begin
			$display("Verification failed");
			$finish;
		end
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
